// ----- sv/ascf_pkg.sv -----
// ---------------------------------------------------------------------------
// ascf_pkg: shared types and constants for the AIS sentence field checker
// Character codes, comma positions, request and result structs, the queue
// entry that links the front and back parts, and small decode helpers.
// ---------------------------------------------------------------------------
package ascf_pkg;

  // Default sizes
  localparam int NumWidthDefault   = 8;
  localparam int QueueDepthDefault = 4;

  // Character codes
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_LC_A  = 8'h61;
  localparam logic [7:0] CH_LC_F  = 8'h66;
  localparam logic [7:0] CH_UC_A  = 8'h41;
  localparam logic [7:0] CH_UC_F  = 8'h46;
  localparam logic [4:0] HEX_ALPHA_OFFSET = 5'd9;

  // Comma counts that open each field
  localparam logic [2:0] COMMA_COUNT   = 3'd1;
  localparam logic [2:0] COMMA_NUMBER  = 3'd2;
  localparam logic [2:0] COMMA_SEQ     = 3'd3;
  localparam logic [2:0] COMMA_CHANNEL = 3'd4;
  localparam logic [2:0] COMMA_PAYLOAD = 3'd5;
  localparam logic [2:0] COMMA_FILL    = 3'd6;

  // Saturation limit of the after-star counter
  localparam logic [1:0] STAR_TAIL_MAX = 2'd2;

  // Number of parsed numeric fields
  localparam int NumFields = 4;

  // Result kinds
  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  typedef struct packed {
    logic [7:0] char_in;
    logic       end_of_sentence;
  } chr_t;

  typedef struct packed {
    logic       item_kind;
    logic [7:0] payload_char;
    logic       checksum_ok;
    logic       well_formed;
    logic [7:0] frag_count;
    logic [7:0] frag_number;
    logic [7:0] seq_id;
    logic [7:0] fill_bits;
    logic [7:0] channel_char;
    logic [3:0] parsed_mask;
  } res_t;

  // One queue entry: up to one payload result and one summary
  typedef struct packed {
    logic       has_payload;
    logic       has_summary;
    logic [7:0] payload_char;
    res_t       summary;
  } entry_t;

  // Hex digit decode: bit 4 is valid, bits 3:0 the value
  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [4:0] r;
    r = '0;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      r = {1'b1, c[3:0]};
    end else if ((c >= CH_LC_A && c <= CH_LC_F) || (c >= CH_UC_A && c <= CH_UC_F)) begin
      r = {1'b1, 4'(5'(c[3:0]) + HEX_ALPHA_OFFSET)};
    end
    return r;
  endfunction

  // Comma count that opens numeric field idx
  function automatic logic [2:0] field_comma(input logic [1:0] idx);
    logic [2:0] r;
    case (idx)
      2'd0:    r = COMMA_COUNT;
      2'd1:    r = COMMA_NUMBER;
      2'd2:    r = COMMA_SEQ;
      default: r = COMMA_FILL;
    endcase
    return r;
  endfunction

endpackage

// ----- sv/ais_sentence_field_checker.sv -----
// ---------------------------------------------------------------------------
// ais_sentence_field_checker: AIS sentence checksum and field parser
// Checks the sentence XOR checksum, streams payload characters and gives a
// field summary at the end of each sentence.
// ---------------------------------------------------------------------------
// Usage:
//   chr channel (chr_valid/chr_ready/chr_data): one sentence byte per request,
//   with end_of_sentence set on the last byte.
//   res channel (res_valid/res_ready/res_data): payload characters (those
//   between the fifth and sixth commas) as they arrive, and one summary
//   after the last byte, always as the final result of a sentence.
// Path: each result passes through the entry queue and the output register
//   after its character is accepted; a summary that follows a payload result
//   on the same character is held and presented once that result is taken.
// Throughput: one character per cycle unless the queue is full. The front
//   registers all running state for each accepted character; the back emits
//   one result per cycle while res_ready is high, so a last character with
//   payload yields two results, absorbed by the entry queue (QUEUE_DEPTH entries).
// Reset: sentence state returns to its start values, the queue empties and
//   no result is shown. When the receiver stalls, the output register holds,
//   the queue fills, and chr_ready drops once the queue is full.
// ---------------------------------------------------------------------------
module ais_sentence_field_checker #(
  parameter int NUM_WIDTH   = ascf_pkg::NumWidthDefault,
  parameter int QUEUE_DEPTH = ascf_pkg::QueueDepthDefault
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           chr_valid,
  output logic           chr_ready,
  input  ascf_pkg::chr_t chr_data,
  output logic           res_valid,
  input  logic           res_ready,
  output ascf_pkg::res_t res_data
);

  logic             take;
  logic             produce;
  ascf_pkg::entry_t entry;
  ascf_pkg::entry_t head;
  logic             empty;
  logic             full;
  logic             pop;

  assign chr_ready = !full;
  assign take      = chr_valid && chr_ready;

  // Classify characters and track sentence state
  ascf_front #(
    .NUM_WIDTH (NUM_WIDTH)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .take    (take),
    .chr     (chr_data),
    .produce (produce),
    .entry   (entry)
  );

  // Buffer entries between front and back
  ascf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (take && produce),
    .push_data (entry),
    .pop       (pop),
    .head      (head),
    .empty     (empty),
    .full      (full)
  );

  // Emit results
  ascf_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .empty     (empty),
    .pop       (pop),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_data  (res_data)
  );

endmodule

// ----- sv/ascf_front.sv -----
// ---------------------------------------------------------------------------
// ascf_front: character classifier and running sentence state
// Tracks checksum, comma count and numeric fields for each accepted
// character and forms the queue entry (payload and/or summary) it causes.
// ---------------------------------------------------------------------------
module ascf_front #(
  parameter int NUM_WIDTH = ascf_pkg::NumWidthDefault
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            take,
  input  ascf_pkg::chr_t  chr,
  output logic            produce,
  output ascf_pkg::entry_t entry
);

  localparam int AW = NUM_WIDTH + 4;

  // Running state
  logic                 at_first_char;
  logic [7:0]           xor_sum;
  logic                 star_seen;
  logic [1:0]           chars_after_star;
  logic [7:0]           hex_value;
  logic [1:0]           hex_digit_flags;
  logic [2:0]           comma_count;
  logic [NUM_WIDTH-1:0] acc [ascf_pkg::NumFields];
  logic [3:0]           fdigit;
  logic [3:0]           flead;
  logic [3:0]           fover;
  logic [7:0]           channel_first;
  logic                 channel_open;

  logic                 at_first_char_next;
  logic [7:0]           xor_sum_next;
  logic                 star_seen_next;
  logic [1:0]           chars_after_star_next;
  logic [7:0]           hex_value_next;
  logic [1:0]           hex_digit_flags_next;
  logic [2:0]           comma_count_next;
  logic [NUM_WIDTH-1:0] acc_next [ascf_pkg::NumFields];
  logic [3:0]           fdigit_next;
  logic [3:0]           flead_next;
  logic [3:0]           fover_next;
  logic [7:0]           channel_first_next;
  logic                 channel_open_next;

  logic [7:0] c;
  logic       is_comma;
  logic       is_digit;
  logic [4:0] hex;

  assign c        = chr.char_in;
  assign is_comma = (c == ascf_pkg::CH_COMMA);
  assign is_digit = (c >= ascf_pkg::CH_ZERO) && (c <= ascf_pkg::CH_NINE);
  assign hex      = ascf_pkg::hex_decode(c);

  // Update checksum state
  always_comb begin
    at_first_char_next    = 1'b0;
    xor_sum_next          = xor_sum;
    star_seen_next        = star_seen;
    chars_after_star_next = chars_after_star;
    hex_value_next        = hex_value;
    hex_digit_flags_next  = hex_digit_flags;
    if (star_seen) begin
      if (chars_after_star == 2'd0) begin
        if (hex[4]) begin
          hex_digit_flags_next[0] = 1'b1;
          hex_value_next          = {4'h0, hex[3:0]};
        end
      end else if (chars_after_star == 2'd1) begin
        if (hex_digit_flags[0] && hex[4]) begin
          hex_digit_flags_next[1] = 1'b1;
          hex_value_next          = {hex_value[3:0], hex[3:0]};
        end
      end
      if (chars_after_star < ascf_pkg::STAR_TAIL_MAX) begin
        chars_after_star_next = chars_after_star + 2'd1;
      end
    end else if (c == ascf_pkg::CH_STAR) begin
      star_seen_next = 1'b1;
    end else if (!at_first_char) begin
      xor_sum_next = xor_sum ^ c;
    end
  end

  // Update comma count, numeric fields and channel
  always_comb begin
    logic [AW-1:0] ext;
    logic [AW-1:0] prod;
    logic [2:0]    code;
    comma_count_next   = comma_count;
    acc_next           = acc;
    fdigit_next        = fdigit;
    flead_next         = flead;
    fover_next         = fover;
    channel_first_next = channel_first;
    channel_open_next  = channel_open;
    ext                = '0;
    prod               = '0;
    code               = '0;

    if (is_comma && comma_count < ascf_pkg::COMMA_FILL) begin
      comma_count_next = comma_count + 3'd1;
      if (comma_count_next == ascf_pkg::COMMA_CHANNEL) begin
        channel_open_next = 1'b1;
      end
    end

    for (int i = 0; i < ascf_pkg::NumFields; i++) begin
      code = ascf_pkg::field_comma(2'(i));
      ext  = AW'(acc[i]);
      prod = (ext << 3) + (ext << 1) + AW'(c[3:0]);
      if (is_comma) begin
        if (comma_count < ascf_pkg::COMMA_FILL && comma_count_next == code) begin
          // Open the field
          acc_next[i]    = '0;
          fdigit_next[i] = 1'b0;
          flead_next[i]  = 1'b1;
          fover_next[i]  = 1'b0;
        end else if (comma_count == code) begin
          flead_next[i] = 1'b0;
        end
      end else if (comma_count == code && flead[i]) begin
        if (is_digit) begin
          fdigit_next[i] = 1'b1;
          if (!fover[i]) begin
            if (prod[AW-1:NUM_WIDTH] != '0) begin
              fover_next[i] = 1'b1;
            end else begin
              acc_next[i] = prod[NUM_WIDTH-1:0];
            end
          end
        end else begin
          flead_next[i] = 1'b0;
        end
      end
    end

    if (!is_comma && comma_count == ascf_pkg::COMMA_CHANNEL && channel_open) begin
      channel_first_next = c;
      channel_open_next  = 1'b0;
    end
  end

  // Form the queue entry
  always_comb begin
    logic [AW-1:0] ext;
    logic [7:0]    val [ascf_pkg::NumFields];
    logic [3:0]    ok;
    logic          wf;
    ext = '0;
    ok  = '0;
    wf  = (comma_count_next == ascf_pkg::COMMA_FILL);
    for (int i = 0; i < ascf_pkg::NumFields; i++) begin
      ext    = AW'(acc_next[i]);
      ok[i]  = wf && fdigit_next[i] && !fover_next[i];
      val[i] = ok[i] ? ext[7:0] : 8'h00;
    end

    entry               = '0;
    entry.has_payload   = !is_comma && (comma_count == ascf_pkg::COMMA_PAYLOAD);
    entry.has_summary   = chr.end_of_sentence;
    entry.payload_char  = c;
    entry.summary.item_kind   = ascf_pkg::KIND_SUMMARY;
    entry.summary.checksum_ok = star_seen_next
                                && (chars_after_star_next >= ascf_pkg::STAR_TAIL_MAX)
                                && hex_digit_flags_next[0]
                                && (xor_sum_next == hex_value_next);
    entry.summary.well_formed  = wf;
    entry.summary.frag_count   = val[0];
    entry.summary.frag_number  = val[1];
    entry.summary.seq_id       = val[2];
    entry.summary.fill_bits    = val[3];
    entry.summary.channel_char = wf ? channel_first_next : 8'h00;
    entry.summary.parsed_mask  = ok;
    produce = entry.has_payload || entry.has_summary;
  end

  // Advance state; return to reset values after the last character
  always_ff @(posedge clk) begin
    if (rst || (take && chr.end_of_sentence)) begin
      at_first_char    <= 1'b1;
      xor_sum          <= '0;
      star_seen        <= 1'b0;
      chars_after_star <= '0;
      hex_value        <= '0;
      hex_digit_flags  <= '0;
      comma_count      <= '0;
      for (int i = 0; i < ascf_pkg::NumFields; i++) begin
        acc[i] <= '0;
      end
      fdigit           <= '0;
      flead            <= '0;
      fover            <= '0;
      channel_first    <= '0;
      channel_open     <= 1'b0;
    end else if (take) begin
      at_first_char    <= at_first_char_next;
      xor_sum          <= xor_sum_next;
      star_seen        <= star_seen_next;
      chars_after_star <= chars_after_star_next;
      hex_value        <= hex_value_next;
      hex_digit_flags  <= hex_digit_flags_next;
      comma_count      <= comma_count_next;
      acc              <= acc_next;
      fdigit           <= fdigit_next;
      flead            <= flead_next;
      fover            <= fover_next;
      channel_first    <= channel_first_next;
      channel_open     <= channel_open_next;
    end
  end

endmodule

// ----- sv/ascf_queue.sv -----
// ---------------------------------------------------------------------------
// ascf_queue: short entry queue between front and back
// Holds classified entries so the front keeps taking characters while the
// back drains a payload and summary pair or waits on the receiver.
// ---------------------------------------------------------------------------
module ascf_queue #(
  parameter int DEPTH = ascf_pkg::QueueDepthDefault
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  ascf_pkg::entry_t push_data,
  input  logic             pop,
  output ascf_pkg::entry_t head,
  output logic             empty,
  output logic             full
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  ascf_pkg::entry_t slots [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;

  assign empty = (count == '0);
  assign full  = (count == CW'(DEPTH));
  assign head  = slots[rd_ptr];

  // Store entries
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !full || pop)
    else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("queue pop while empty");
  a_count_up: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> (count == $past(count) + CW'(1)))
    else $error("queue count did not advance on push");

endmodule

// ----- sv/ascf_back.sv -----
// ---------------------------------------------------------------------------
// ascf_back: result sequencer and output register
// Pops queue entries and presents their payload and summary results one
// per cycle while res_ready is high on the result channel, payload first.
// ---------------------------------------------------------------------------
module ascf_back (
  input  logic             clk,
  input  logic             rst,
  input  ascf_pkg::entry_t head,
  input  logic             empty,
  output logic             pop,
  output logic             res_valid,
  input  logic             res_ready,
  output ascf_pkg::res_t   res_data
);

  logic           sum_pend;
  ascf_pkg::res_t sum_data;
  ascf_pkg::res_t pay_item;
  logic           load;

  assign load = !res_valid || res_ready;
  assign pop  = load && !sum_pend && !empty;

  // Build the payload result
  always_comb begin
    pay_item              = '0;
    pay_item.item_kind    = ascf_pkg::KIND_PAYLOAD;
    pay_item.payload_char = head.payload_char;
  end

  // Load the output register: held summary first, then the next entry
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
      sum_pend  <= 1'b0;
    end else if (load) begin
      if (sum_pend) begin
        res_valid <= 1'b1;
        res_data  <= sum_data;
        sum_pend  <= 1'b0;
      end else if (!empty) begin
        res_valid <= 1'b1;
        if (head.has_payload) begin
          res_data <= pay_item;
          sum_pend <= head.has_summary;
          sum_data <= head.summary;
        end else begin
          res_data <= head.summary;
        end
      end else begin
        res_valid <= 1'b0;
      end
    end
  end

  a_pend_behind_payload: assert property (@(posedge clk) disable iff (rst)
    sum_pend |-> (res_valid && res_data.item_kind == ascf_pkg::KIND_PAYLOAD))
    else $error("held summary without a payload in front");
  a_pend_follows: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_ready && sum_pend) |=>
      (res_valid && res_data.item_kind == ascf_pkg::KIND_SUMMARY))
    else $error("held summary not presented next");
  a_pop_clean: assert property (@(posedge clk) disable iff (rst)
    pop |-> (!sum_pend && (!res_valid || res_ready)))
    else $error("entry popped while a result is still held");

endmodule
